FILE: hw/rtl/mlpt_pkg.sv
// Shared constants, types and helper functions of the multilevel page table.
package mlpt_pkg;

   // Default sizing of the table and of the channel fields.
   localparam int MAX_LEVELS   = 4;
   localparam int POOL_ENTRIES = 65536;
   localparam int FRAME_BITS   = 20;
   localparam int ADDRESS_BITS = 32;

   // Number of levels that the datapath can walk.
   localparam int LEVEL_LIMIT  = (MAX_LEVELS < 4) ? MAX_LEVELS : 4;

   // Fixed field widths.
   localparam int STATUS_W     = 2;
   localparam int INDEX_W      = 16;
   localparam int COUNT_W      = 17;
   localparam int LCOUNT_W     = 3;
   localparam int LBITS_W      = 5;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 5;
   localparam int BITS_MAX     = 16;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [LBITS_W-1:0]  lbits_type;

   // Result codes.
   localparam status_type ST_DONE   = 2'd0;
   localparam status_type ST_MAPPED = 2'd1;
   localparam status_type ST_MISS   = 2'd2;
   localparam status_type ST_FULL   = 2'd3;

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_BITS0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_BITS1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_BITS2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_BITS3 = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [LCOUNT_W-1:0] LEVEL_COUNT_RESET = 3'd2;
   localparam lbits_type LEVEL_BITS0_RESET = 5'd10;
   localparam lbits_type LEVEL_BITS1_RESET = 5'd10;
   localparam lbits_type LEVEL_BITS2_RESET = 5'd4;
   localparam lbits_type LEVEL_BITS3_RESET = 5'd4;

   // A level width is held to the range one to sixteen.
   function automatic lbits_type clamp_bits(input lbits_type b);
      if (b == 5'd0) begin
         return 5'd1;
      end
      if (b > lbits_type'(BITS_MAX)) begin
         return lbits_type'(BITS_MAX);
      end
      return b;
   endfunction

endpackage

FILE: hw/rtl/mlpt_channels.sv
// Handshake interfaces of the request, response and configuration channels.
interface mlpt_req_if #(
   parameter int ADDRESS_BITS = mlpt_pkg::ADDRESS_BITS,
   parameter int FRAME_BITS   = mlpt_pkg::FRAME_BITS
);
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [ADDRESS_BITS-1:0] virtual_address;
   logic [FRAME_BITS-1:0]   frame_number;

   modport source (output valid, output opcode, output virtual_address,
                   output frame_number, input ready);
   modport sink   (input valid, input opcode, input virtual_address,
                   input frame_number, output ready);
endinterface

interface mlpt_rsp_if #(
   parameter int FRAME_BITS = mlpt_pkg::FRAME_BITS
);
   logic                             valid;
   logic                             ready;
   mlpt_pkg::status_type             status;
   logic [FRAME_BITS-1:0]            frame_out;
   mlpt_pkg::index_type              index_level0;
   mlpt_pkg::index_type              index_level1;
   mlpt_pkg::index_type              index_level2;
   mlpt_pkg::index_type              index_level3;
   logic [mlpt_pkg::COUNT_W-1:0]     entries_used;
   logic [mlpt_pkg::COUNT_W-1:0]     frames_mapped;

   modport source (output valid, output status, output frame_out,
                   output index_level0, output index_level1, output index_level2,
                   output index_level3, output entries_used, output frames_mapped,
                   input ready);
   modport sink   (input valid, input status, input frame_out,
                   input index_level0, input index_level1, input index_level2,
                   input index_level3, input entries_used, input frames_mapped,
                   output ready);
endinterface

interface mlpt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mlpt_pkg::CSR_INDEX_W-1:0]   index;
   logic [mlpt_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/multilevel_page_table_top.sv
// A request runs through the index steps, one per level, the root check, a read and a decide
// step per level, and the load of the response register.
// A miss or a full pool ends the walk early. A new request is taken only once the result has
// entered the response register, which waits while the previous response word is not taken.
// After reset a clearing pass writes every pool entry (POOL_ENTRIES of them, 65536 by
// default), while no request is accepted; configuration writes are taken throughout.
module multilevel_page_table_top #(
   parameter int POOL_ENTRIES = mlpt_pkg::POOL_ENTRIES,
   parameter int FRAME_BITS   = mlpt_pkg::FRAME_BITS,
   parameter int ADDRESS_BITS = mlpt_pkg::ADDRESS_BITS
) (
   input logic       clock,
   input logic       reset,
   mlpt_req_if.sink   req_port,
   mlpt_rsp_if.source rsp_port,
   mlpt_csr_if.sink   csr_port
);

   // Derived widths.
   localparam int PTR_W   = $clog2(POOL_ENTRIES);
   localparam int CNT_W   = $clog2(POOL_ENTRIES + 1);
   localparam int PAY_W   = (FRAME_BITS > PTR_W) ? FRAME_BITS : PTR_W;
   localparam int ENTRY_W = PAY_W + 1;
   localparam int SUM_RAW = ((PAY_W > mlpt_pkg::INDEX_W) ? PAY_W : mlpt_pkg::INDEX_W) + 1;
   localparam int S_W     = (SUM_RAW > 32) ? 32 : SUM_RAW;
   localparam int SIZE_W  = mlpt_pkg::BITS_MAX + 1;
   localparam int ALLOC_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
   localparam int EXT_W   = ADDRESS_BITS + mlpt_pkg::INDEX_W;
   localparam int SH_W    = $clog2(EXT_W + 1);
   localparam int CUM_W   = $clog2(4 * mlpt_pkg::BITS_MAX + 1);

   // Controller states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_INDEX = 3'd2;
   localparam logic [2:0] S_ROOT  = 3'd3;
   localparam logic [2:0] S_ISSUE = 3'd4;
   localparam logic [2:0] S_WAIT  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // Control registers.
   logic [2:0]                     state_ff, state_in;
   logic [PTR_W-1:0]               clear_ff, clear_in;
   logic                           root_ff, root_in;
   logic [CNT_W-1:0]               next_free_ff, next_free_in;
   logic [CNT_W-1:0]               mapped_ff, mapped_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mlpt_pkg::LCOUNT_W-1:0]  level_count_ff, level_count_in;
   mlpt_pkg::lbits_type            level_bits_ff [4];
   mlpt_pkg::lbits_type            level_bits_in [4];

   // Walk payload registers.
   logic [1:0]                     lvl_ff, lvl_in;
   logic [CUM_W-1:0]               cum_ff, cum_in;
   logic                           op_ff, op_in;
   logic [ADDRESS_BITS-1:0]        addr_ff, addr_in;
   logic [FRAME_BITS-1:0]          frame_ff, frame_in;
   mlpt_pkg::index_type            idx_ff [4];
   mlpt_pkg::index_type            idx_in [4];
   logic [PAY_W-1:0]               base_ff, base_in;
   logic [S_W-1:0]                 slot_ff, slot_in;
   mlpt_pkg::status_type           status_ff, status_in;
   logic [FRAME_BITS-1:0]          found_ff, found_in;

   // Response payload registers.
   mlpt_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [FRAME_BITS-1:0]          rsp_frame_ff, rsp_frame_in;
   mlpt_pkg::index_type            rsp_idx_ff [4];
   mlpt_pkg::index_type            rsp_idx_in [4];
   logic [mlpt_pkg::COUNT_W-1:0]   rsp_used_ff, rsp_used_in;
   logic [mlpt_pkg::COUNT_W-1:0]   rsp_mapped_ff, rsp_mapped_in;

   // Node pool and its registered read data.
   logic [ENTRY_W-1:0]             entry_store_ff [POOL_ENTRIES];
   logic [ENTRY_W-1:0]             rdata_ff;
   logic                           mem_we;
   logic [PTR_W-1:0]               mem_waddr;
   logic [ENTRY_W-1:0]             mem_wdata;
   logic                           mem_re;
   logic [PTR_W-1:0]               mem_raddr;

   // Datapath helpers.
   logic [mlpt_pkg::LCOUNT_W-1:0]  levels;
   logic [1:0]                     lvl_last;
   mlpt_pkg::lbits_type            cur_bits;
   mlpt_pkg::lbits_type            child_bits;
   mlpt_pkg::lbits_type            root_bits;
   logic [EXT_W-1:0]               addr_ext;
   logic [SH_W-1:0]                shift_amt;
   logic [EXT_W-1:0]               shifted;
   mlpt_pkg::index_type            index_mask;
   mlpt_pkg::index_type            level_index;
   logic [S_W-1:0]                 slot_sum;
   logic                           slot_out;
   logic [SIZE_W-1:0]              root_size;
   logic [SIZE_W-1:0]              child_size;
   logic                           root_fits;
   logic                           child_fits;
   logic                           rd_valid;
   logic [PAY_W-1:0]               rd_payload;
   logic                           rsp_free;

   assign req_port.ready = (state_ff == S_IDLE);
   assign csr_port.ready = 1'b1;

   // Levels in use, held to the supported range.
   always_comb begin
      levels = level_count_ff;
      if (levels == '0) begin
         levels = mlpt_pkg::LCOUNT_W'(1);
      end
      if (levels > mlpt_pkg::LCOUNT_W'(mlpt_pkg::LEVEL_LIMIT)) begin
         levels = mlpt_pkg::LCOUNT_W'(mlpt_pkg::LEVEL_LIMIT);
      end
      lvl_last = 2'(levels - mlpt_pkg::LCOUNT_W'(1));
   end

   // Index of the current level, taken from the address with zeros below bit 0.
   always_comb begin
      cur_bits   = mlpt_pkg::clamp_bits(level_bits_ff[lvl_ff]);
      child_bits = mlpt_pkg::clamp_bits(level_bits_ff[2'(lvl_ff + 2'd1)]);
      root_bits  = mlpt_pkg::clamp_bits(level_bits_ff[0]);
      addr_ext   = {addr_ff, {mlpt_pkg::INDEX_W{1'b0}}};
      index_mask = mlpt_pkg::INDEX_W'((SIZE_W'(1) << cur_bits) - SIZE_W'(1));
      shift_amt  = '0;
      if (int'(cum_ff) < ADDRESS_BITS) begin
         shift_amt = SH_W'(EXT_W) - SH_W'(cum_ff) - SH_W'(cur_bits);
      end
      shifted     = addr_ext >> shift_amt;
      level_index = (int'(cum_ff) < ADDRESS_BITS) ?
                    (shifted[mlpt_pkg::INDEX_W-1:0] & index_mask) : '0;
   end

   // Slot arithmetic and allocation checks.
   always_comb begin
      slot_sum   = S_W'(base_ff) + S_W'(idx_ff[lvl_ff]);
      slot_out   = (slot_sum >= S_W'(next_free_ff));
      root_size  = SIZE_W'(1) << root_bits;
      child_size = SIZE_W'(1) << child_bits;
      root_fits  = (ALLOC_W'(next_free_ff) + ALLOC_W'(root_size)) <= ALLOC_W'(POOL_ENTRIES);
      child_fits = (ALLOC_W'(next_free_ff) + ALLOC_W'(child_size)) <= ALLOC_W'(POOL_ENTRIES);
      rd_valid   = rdata_ff[PAY_W];
      rd_payload = rdata_ff[PAY_W-1:0];
      rsp_free   = !rsp_valid_ff || rsp_port.ready;
   end

   // Main controller: clearing pass, index phase, table walk and result hand-off.
   always_comb begin
      state_in       = state_ff;
      clear_in       = clear_ff;
      root_in        = root_ff;
      next_free_in   = next_free_ff;
      mapped_in      = mapped_ff;
      rsp_valid_in   = rsp_valid_ff;
      level_count_in = level_count_ff;
      level_bits_in  = level_bits_ff;
      lvl_in         = lvl_ff;
      cum_in         = cum_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      frame_in       = frame_ff;
      idx_in         = idx_ff;
      base_in        = base_ff;
      slot_in        = slot_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_mapped_in  = rsp_mapped_ff;
      mem_we         = 1'b0;
      mem_waddr      = slot_ff[PTR_W-1:0];
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = slot_sum[PTR_W-1:0];

      // A taken response word frees the output register.
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_port.valid) begin
         case (csr_port.index)
            mlpt_pkg::REG_LEVEL_COUNT: level_count_in = csr_port.data[mlpt_pkg::LCOUNT_W-1:0];
            mlpt_pkg::REG_LEVEL_BITS0: level_bits_in[0] = csr_port.data;
            mlpt_pkg::REG_LEVEL_BITS1: level_bits_in[1] = csr_port.data;
            mlpt_pkg::REG_LEVEL_BITS2: level_bits_in[2] = csr_port.data;
            mlpt_pkg::REG_LEVEL_BITS3: level_bits_in[3] = csr_port.data;
            default: ;
         endcase
      end

      case (state_ff)
         // Write every pool entry invalid, one a cycle.
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_ff;
            clear_in  = clear_ff + PTR_W'(1);
            if (clear_ff == PTR_W'(POOL_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         // Take a request word.
         S_IDLE: begin
            if (req_port.valid) begin
               op_in     = req_port.opcode;
               addr_in   = req_port.virtual_address;
               frame_in  = req_port.frame_number;
               lvl_in    = '0;
               cum_in    = '0;
               for (int i = 0; i < 4; i++) begin
                  idx_in[i] = '0;
               end
               status_in = mlpt_pkg::ST_DONE;
               found_in  = '0;
               state_in  = S_INDEX;
            end
         end
         // One level index per cycle.
         S_INDEX: begin
            idx_in[lvl_ff] = level_index;
            cum_in         = cum_ff + CUM_W'(cur_bits);
            if (lvl_ff == lvl_last) begin
               lvl_in   = '0;
               state_in = S_ROOT;
            end else begin
               lvl_in = lvl_ff + 2'd1;
            end
         end
         // Root node check and allocation.
         S_ROOT: begin
            base_in = '0;
            if (op_ff == mlpt_pkg::OP_LOOKUP) begin
               if (root_ff) begin
                  state_in = S_ISSUE;
               end else begin
                  status_in = mlpt_pkg::ST_MISS;
                  state_in  = S_DONE;
               end
            end else if (root_ff) begin
               state_in = S_ISSUE;
            end else if (root_fits) begin
               root_in      = 1'b1;
               next_free_in = next_free_ff + CNT_W'(root_size);
               state_in     = S_ISSUE;
            end else begin
               status_in = mlpt_pkg::ST_FULL;
               state_in  = S_DONE;
            end
         end
         // Read the slot of this level, unless it lies beyond the allocated pool.
         S_ISSUE: begin
            slot_in = slot_sum;
            if (slot_out) begin
               status_in = (op_ff == mlpt_pkg::OP_LOOKUP) ? mlpt_pkg::ST_MISS
                                                          : mlpt_pkg::ST_FULL;
               state_in  = S_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = S_WAIT;
            end
         end
         // Act on the entry read and write back where the insert changes it.
         S_WAIT: begin
            if (op_ff == mlpt_pkg::OP_LOOKUP) begin
               if (!rd_valid) begin
                  status_in = mlpt_pkg::ST_MISS;
                  state_in  = S_DONE;
               end else if (lvl_ff == lvl_last) begin
                  found_in = rd_payload[FRAME_BITS-1:0];
                  state_in = S_DONE;
               end else begin
                  base_in  = rd_payload;
                  lvl_in   = lvl_ff + 2'd1;
                  state_in = S_ISSUE;
               end
            end else if (lvl_ff == lvl_last) begin
               if (rd_valid) begin
                  status_in = mlpt_pkg::ST_MAPPED;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = {1'b1, PAY_W'(frame_ff)};
                  mapped_in = mapped_ff + CNT_W'(1);
               end
               state_in = S_DONE;
            end else if (rd_valid) begin
               base_in  = rd_payload;
               lvl_in   = lvl_ff + 2'd1;
               state_in = S_ISSUE;
            end else if (child_fits) begin
               mem_we       = 1'b1;
               mem_wdata    = {1'b1, PAY_W'(next_free_ff)};
               base_in      = PAY_W'(next_free_ff);
               next_free_in = next_free_ff + CNT_W'(child_size);
               lvl_in       = lvl_ff + 2'd1;
               state_in     = S_ISSUE;
            end else begin
               status_in = mlpt_pkg::ST_FULL;
               state_in  = S_DONE;
            end
         end
         // Load the response register once it is free.
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_frame_in  = found_ff;
               rsp_idx_in    = idx_ff;
               rsp_used_in   = mlpt_pkg::COUNT_W'(next_free_ff);
               rsp_mapped_in = mlpt_pkg::COUNT_W'(mapped_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clear_ff         <= '0;
         root_ff          <= 1'b0;
         next_free_ff     <= '0;
         mapped_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         level_count_ff   <= mlpt_pkg::LEVEL_COUNT_RESET;
         level_bits_ff[0] <= mlpt_pkg::LEVEL_BITS0_RESET;
         level_bits_ff[1] <= mlpt_pkg::LEVEL_BITS1_RESET;
         level_bits_ff[2] <= mlpt_pkg::LEVEL_BITS2_RESET;
         level_bits_ff[3] <= mlpt_pkg::LEVEL_BITS3_RESET;
      end else begin
         state_ff       <= state_in;
         clear_ff       <= clear_in;
         root_ff        <= root_in;
         next_free_ff   <= next_free_in;
         mapped_ff      <= mapped_in;
         rsp_valid_ff   <= rsp_valid_in;
         level_count_ff <= level_count_in;
         level_bits_ff  <= level_bits_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lvl_ff        <= lvl_in;
      cum_ff        <= cum_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      frame_ff      <= frame_in;
      idx_ff        <= idx_in;
      base_ff       <= base_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_mapped_ff <= rsp_mapped_in;
   end

   // Node pool: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= entry_store_ff[mem_raddr];
      end
   end

   // Response outputs.
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = rsp_status_ff;
   assign rsp_port.frame_out     = rsp_frame_ff;
   assign rsp_port.index_level0  = rsp_idx_ff[0];
   assign rsp_port.index_level1  = rsp_idx_ff[1];
   assign rsp_port.index_level2  = rsp_idx_ff[2];
   assign rsp_port.index_level3  = rsp_idx_ff[3];
   assign rsp_port.entries_used  = rsp_used_ff;
   assign rsp_port.frames_mapped = rsp_mapped_ff;

`ifndef SYNTHESIS
   // No request is taken during the clearing pass.
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_port.ready)
      else $error("request accepted during clearing pass");

   // The bump pointer never passes the end of the pool.
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(next_free_ff) <= (CNT_W + 1)'(POOL_ENTRIES))
      else $error("bump pointer beyond pool");

   // The pool is not written while the block waits for a request.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("pool written while idle");

   // A response word appears only on leaving the result state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside result state");

   // Leaf mappings never outnumber allocated entries.
   a_mapped_bound: assert property (@(posedge clock) disable iff (reset)
      mapped_ff <= next_free_ff)
      else $error("mapping count above entry count");
`endif

endmodule

FILE: tb/multilevel_page_table_top_tb.sv
// Self-checking testbench of the multilevel page table: random and directed walks against a predictor.
module multilevel_page_table_top_tb;
   import mlpt_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 30;
   localparam int PRESSURE_CYCLES = 250;
   localparam int PHASES          = 6;
   localparam int RANDOM_FIRST    = 70;
   localparam int RANDOM_LATER    = 55;

   // Register settings of the later phases: level count, then the four level widths.
   // Out-of-range values are there on purpose, so that the clamping is exercised.
   localparam logic [CSR_DATA_W-1:0] PHASE_SETTINGS [PHASES][5] = '{
      '{5'd3, 5'd4,  5'd6,  5'd2,  5'd1},
      '{5'd4, 5'd2,  5'd3,  5'd1,  5'd2},
      '{5'd1, 5'd16, 5'd10, 5'd4,  5'd4},
      '{5'd7, 5'd0,  5'd31, 5'd16, 5'd16},
      '{5'd0, 5'd12, 5'd1,  5'd1,  5'd1},
      '{5'd2, 5'd10, 5'd10, 5'd4,  5'd4}
   };

   typedef struct {
      logic                    opcode;
      logic [ADDRESS_BITS-1:0] vaddr;
      logic [FRAME_BITS-1:0]   frame;
   } page_request;

   typedef struct {
      status_type            status;
      logic [FRAME_BITS-1:0] frame;
      index_type             index0;
      index_type             index1;
      index_type             index2;
      index_type             index3;
      logic [COUNT_W-1:0]    entries;
      logic [COUNT_W-1:0]    mappings;
   } walk_result;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlpt_req_if req_if ();
   mlpt_rsp_if rsp_if ();
   mlpt_csr_if csr_if ();

   multilevel_page_table_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // Shadow copy of the node pool and of the counters that the table keeps.
   bit                  slot_valid   [POOL_ENTRIES];
   bit [31:0]           slot_payload [POOL_ENTRIES];
   bit                  root_present  = 1'b0;
   int unsigned         bump_ptr      = 0;
   int unsigned         entry_count   = 0;
   int unsigned         mapping_count = 0;
   logic [LCOUNT_W-1:0] cfg_levels    = LEVEL_COUNT_RESET;
   lbits_type           cfg_width [4] = '{LEVEL_BITS0_RESET, LEVEL_BITS1_RESET,
                                          LEVEL_BITS2_RESET, LEVEL_BITS3_RESET};

   page_request                   pending_requests [$];
   walk_result                    expected_walks [$];
   logic [ADDRESS_BITS-1:0]       known_vaddrs [$];
   logic [7:0]                    hot_prefix [8];

   bit offering    = 1'b0;
   bit req_taken   = 1'b0;
   bit rsp_taken   = 1'b0;
   bit idle_on     = 1'b1;
   bit pressure_go = 1'b0;
   bit rsp_hold    = 1'b0;
   int error_count = 0;
   int cycle_count = 0;

   // Free-running clock, period of twelve units.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Works out the result of one request and updates the shadow table as the block would.
   function automatic walk_result predict_access(input page_request rq);
      int          width [4];
      int unsigned idx [4];
      int unsigned nlev;
      int unsigned slot;
      int unsigned base;
      int unsigned size;
      int          top;
      int          lv;
      logic [63:0] addr64;
      logic [63:0] mask;
      walk_result  res;

      nlev = cfg_levels;
      if (nlev < 1) nlev = 1;
      if (nlev > LEVEL_LIMIT) nlev = LEVEL_LIMIT;
      for (lv = 0; lv < 4; lv++) begin
         width[lv] = (cfg_width[lv] == 0) ? 1 : (cfg_width[lv] > BITS_MAX) ? BITS_MAX
                                                                          : int'(cfg_width[lv]);
         idx[lv] = 0;
      end

      // Indices come from the top of the address down; bits below bit zero read as zero.
      addr64 = 64'(rq.vaddr);
      top    = ADDRESS_BITS;
      for (lv = 0; lv < int'(nlev); lv++) begin
         mask = (64'd1 << width[lv]) - 64'd1;
         if (top <= 0) begin
            idx[lv] = 0;
         end else if (top >= width[lv]) begin
            idx[lv] = int'((addr64 >> (top - width[lv])) & mask);
         end else begin
            idx[lv] = int'((addr64 << (width[lv] - top)) & mask);
         end
         top -= width[lv];
      end

      res        = '{default: '0};
      res.status = ST_DONE;
      base       = 0;

      if (rq.opcode == OP_LOOKUP) begin
         res.status = ST_MISS;
         if (root_present) begin
            for (lv = 0; lv < int'(nlev); lv++) begin
               slot = base + idx[lv];
               if (slot >= bump_ptr || slot >= POOL_ENTRIES || !slot_valid[slot]) break;
               if (lv == int'(nlev) - 1) begin
                  res.status = ST_DONE;
                  res.frame  = slot_payload[slot][FRAME_BITS-1:0];
               end else begin
                  base = slot_payload[slot];
               end
            end
         end
      end else begin
         // The root node is placed at slot zero by the first insert that fits.
         if (!root_present) begin
            size = 1 << width[0];
            if (bump_ptr + size > POOL_ENTRIES) begin
               res.status = ST_FULL;
            end else begin
               root_present = 1'b1;
               bump_ptr    += size;
               entry_count += size;
            end
         end
         if (res.status == ST_DONE) begin
            for (lv = 0; lv < int'(nlev); lv++) begin
               slot = base + idx[lv];
               if (slot >= bump_ptr || slot >= POOL_ENTRIES) begin
                  res.status = ST_FULL;
                  break;
               end
               if (lv == int'(nlev) - 1) begin
                  if (slot_valid[slot]) begin
                     res.status = ST_MAPPED;
                  end else begin
                     slot_valid[slot]   = 1'b1;
                     slot_payload[slot] = 32'(rq.frame);
                     mapping_count++;
                  end
               end else if (slot_valid[slot]) begin
                  base = slot_payload[slot];
               end else begin
                  // Missing inner node: take it from the bump pointer if it fits.
                  size = 1 << width[lv + 1];
                  if (bump_ptr + size > POOL_ENTRIES) begin
                     res.status = ST_FULL;
                     break;
                  end
                  slot_valid[slot]   = 1'b1;
                  slot_payload[slot] = bump_ptr;
                  base               = bump_ptr;
                  bump_ptr          += size;
                  entry_count       += size;
               end
            end
         end
      end

      res.index0   = index_type'(idx[0]);
      res.index1   = index_type'(idx[1]);
      res.index2   = index_type'(idx[2]);
      res.index3   = index_type'(idx[3]);
      res.entries  = COUNT_W'(entry_count);
      res.mappings = COUNT_W'(mapping_count);
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Queues one request word and remembers the address of every insert.
   task automatic queue_request(input logic op, input logic [ADDRESS_BITS-1:0] addr,
                                input logic [FRAME_BITS-1:0] frame);
      page_request rq;
      rq.opcode = op;
      rq.vaddr  = addr;
      rq.frame  = frame;
      pending_requests.push_back(rq);
      if (op == OP_INSERT) known_vaddrs.push_back(addr);
   endtask

   // Writes one register; valid is left high so that writes can follow back to back.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || offering || expected_walks.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: offers one word at a time, with a random gap after each accepted word when idle_on.
   always @(negedge clock) begin : request_driver
      page_request current;
      int          send_gap;
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            offering  = 1'b0;
            send_gap  = idle_on ? $urandom_range(0, 12) : 0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               current                = pending_requests.pop_front();
               req_if.opcode          <= current.opcode;
               req_if.virtual_address <= current.vaddr;
               req_if.frame_number    <= current.frame;
               offering = 1'b1;
            end
         end
         req_if.valid <= offering;
      end
   end

   // Response receiver: stalls for a random spell after each word when idle_on, or while held off.
   always @(negedge clock) begin : response_receiver
      int rsp_stall;
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_stall = idle_on ? $urandom_range(0, 12) : 0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_if.ready <= (rsp_stall == 0) && !rsp_hold;
      end
   end

   // Long hold-off of the receiver, so that the block backs up and stalls its input.
   initial begin : response_hold_off
      wait (pressure_go);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (PRESSURE_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // Monitor: tracks register writes, predicts each accepted request and checks each response.
   always @(posedge clock) begin : monitor
      walk_result  want;
      page_request seen;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == REG_LEVEL_COUNT) begin
               cfg_levels = csr_if.data[LCOUNT_W-1:0];
            end else if (csr_if.index == REG_LEVEL_BITS0) begin
               cfg_width[0] = csr_if.data;
            end else if (csr_if.index == REG_LEVEL_BITS1) begin
               cfg_width[1] = csr_if.data;
            end else if (csr_if.index == REG_LEVEL_BITS2) begin
               cfg_width[2] = csr_if.data;
            end else if (csr_if.index == REG_LEVEL_BITS3) begin
               cfg_width[3] = csr_if.data;
            end
         end
         if (req_if.valid && req_if.ready) begin
            seen.opcode = req_if.opcode;
            seen.vaddr  = req_if.virtual_address;
            seen.frame  = req_if.frame_number;
            expected_walks.push_back(predict_access(seen));
            req_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_taken = 1'b1;
            if (expected_walks.size() == 0) begin
               $display("%0t: response word with none expected, status %0h", $time,
                        rsp_if.status);
               error_count++;
            end else begin
               want = expected_walks.pop_front();
               check_field("status",        32'(want.status),   32'(rsp_if.status));
               check_field("frame_out",     32'(want.frame),    32'(rsp_if.frame_out));
               check_field("index_level0",  32'(want.index0),   32'(rsp_if.index_level0));
               check_field("index_level1",  32'(want.index1),   32'(rsp_if.index_level1));
               check_field("index_level2",  32'(want.index2),   32'(rsp_if.index_level2));
               check_field("index_level3",  32'(want.index3),   32'(rsp_if.index_level3));
               check_field("entries_used",  32'(want.entries),  32'(rsp_if.entries_used));
               check_field("frames_mapped", 32'(want.mappings), 32'(rsp_if.frames_mapped));
            end
         end
      end
   end

   // Watchdog on the total run time, which includes the clearing pass after reset.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus: directed words first, then phases of random words under changing settings.
   initial begin : stimulus
      int                      ph;
      int                      k;
      int unsigned             pick;
      int                      count;
      logic [ADDRESS_BITS-1:0] addr;

      req_if.valid           = 1'b0;
      req_if.opcode          = OP_INSERT;
      req_if.virtual_address = '0;
      req_if.frame_number    = '0;
      rsp_if.ready           = 1'b0;
      csr_if.valid           = 1'b0;
      csr_if.index           = REG_LEVEL_COUNT;
      csr_if.data            = '0;

      // Hot prefixes keep most random addresses on shared paths, so that walks go deep.
      hot_prefix[0] = 8'h00;
      for (k = 1; k < 8; k++) hot_prefix[k] = 8'($urandom);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: lookup before the root exists, extremes, remapping and misses.
      queue_request(OP_LOOKUP, 32'h0000_0000, 20'h00000);
      queue_request(OP_INSERT, 32'h0000_0000, 20'h00000);
      queue_request(OP_INSERT, 32'hFFFF_FFFF, 20'hFFFFF);
      queue_request(OP_INSERT, 32'h0000_0000, 20'h12345);
      queue_request(OP_LOOKUP, 32'h0000_0000, 20'hFFFFF);
      queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000);
      queue_request(OP_LOOKUP, 32'h0000_1000, 20'h00000);
      queue_request(OP_LOOKUP, 32'h8000_0000, 20'h00000);
      queue_request(OP_INSERT, 32'hAAAA_AAAA, 20'hAAAAA);
      queue_request(OP_INSERT, 32'h5555_5555, 20'h55555);
      queue_request(OP_LOOKUP, 32'hAAAA_AAAA, 20'h00000);
      queue_request(OP_LOOKUP, 32'h5555_5555, 20'h00000);

      for (ph = 0; ph <= PHASES; ph++) begin
         if (ph > 0) begin
            wait_until_drained();
            write_register(REG_LEVEL_COUNT, PHASE_SETTINGS[ph-1][0]);
            write_register(REG_LEVEL_BITS0, PHASE_SETTINGS[ph-1][1]);
            write_register(REG_LEVEL_BITS1, PHASE_SETTINGS[ph-1][2]);
            write_register(REG_LEVEL_BITS2, PHASE_SETTINGS[ph-1][3]);
            write_register(REG_LEVEL_BITS3, PHASE_SETTINGS[ph-1][4]);
            @(negedge clock);
            csr_if.valid <= 1'b0;
            // Old paths walked under the new layout, and the top and bottom addresses.
            queue_request(OP_LOOKUP, 32'h0000_0000, 20'h00000);
            queue_request(OP_INSERT, 32'hFFFF_FFFF, 20'($urandom));
         end
         idle_on <= (ph != 2);
         if (ph == 1) pressure_go <= 1'b1;

         count = (ph == 0) ? RANDOM_FIRST : RANDOM_LATER;
         for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            addr = {hot_prefix[$urandom_range(0, 7)], 24'($urandom)};
            if (pick < 40) begin
               queue_request(OP_INSERT, addr, 20'($urandom));
            end else if (pick < 70 && known_vaddrs.size() > 0) begin
               queue_request(OP_LOOKUP, known_vaddrs[$urandom_range(0, known_vaddrs.size() - 1)],
                             20'($urandom));
            end else if (pick < 78 && known_vaddrs.size() > 0) begin
               queue_request(OP_INSERT, known_vaddrs[$urandom_range(0, known_vaddrs.size() - 1)],
                             20'($urandom));
            end else if (pick < 90) begin
               queue_request(OP_LOOKUP, 32'($urandom), 20'($urandom));
            end else begin
               queue_request(OP_INSERT, 32'($urandom), 20'($urandom));
            end
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: multilevel_page_table_top.f
hw/rtl/mlpt_pkg.sv
hw/rtl/mlpt_channels.sv
hw/rtl/multilevel_page_table_top.sv
tb/multilevel_page_table_top_tb.sv
